// ===== hw/rtl/fir_pcm_pkg.sv =====
// Package for the PCM16 FIR filter: widths, register indexes, config struct.
// No dependencies; used by every design module of the block.
package fir_pcm_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned NUM_COEFS      = 16;
  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned TAP_CNT_W      = 5;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned COEFS_PER_WORD = WORD_W / COEF_W;
  localparam int unsigned NUM_WORDS      = NUM_COEFS / COEFS_PER_WORD;

  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned GRP      = 4;
  localparam int unsigned NUM_GRP  = NUM_COEFS / GRP;
  localparam int unsigned PSUM_W   = PROD_W + $clog2(GRP);
  localparam int unsigned ACC_W    = PSUM_W + $clog2(NUM_GRP) + 1;

  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_0    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_3    = 3'd4;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 5'd1;
  localparam logic [WORD_W-1:0]    COEF_0_RST    = 64'd16384;

  typedef struct packed {
    logic [TAP_CNT_W-1:0]               tap_count;
    logic [NUM_COEFS-1:0][COEF_W-1:0]   coef;
  } cfg_t;

endpackage

// ===== hw/rtl/fir_pcm_regs.sv =====
// Configuration registers: tap count and four packed coefficient words.
// Depends on fir_pcm_pkg.
module fir_pcm_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fir_pcm_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fir_pcm_pkg::WORD_W-1:0]        cfg_data_i,
  output fir_pcm_pkg::cfg_t                     cfg_o
);

  logic [fir_pcm_pkg::TAP_CNT_W-1:0] tap_count_q;
  logic [fir_pcm_pkg::WORD_W-1:0]    word_q [fir_pcm_pkg::NUM_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fir_pcm_pkg::TAP_COUNT_RST;
      word_q[0]   <= fir_pcm_pkg::COEF_0_RST;
      word_q[1]   <= '0;
      word_q[2]   <= '0;
      word_q[3]   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fir_pcm_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data_i[fir_pcm_pkg::TAP_CNT_W-1:0];
        fir_pcm_pkg::REG_COEF_0:    word_q[0]   <= cfg_data_i;
        fir_pcm_pkg::REG_COEF_1:    word_q[1]   <= cfg_data_i;
        fir_pcm_pkg::REG_COEF_2:    word_q[2]   <= cfg_data_i;
        fir_pcm_pkg::REG_COEF_3:    word_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.tap_count = tap_count_q;
    for (int w = 0; w < fir_pcm_pkg::NUM_WORDS; w++) begin
      for (int c = 0; c < fir_pcm_pkg::COEFS_PER_WORD; c++) begin
        cfg_o.coef[w*fir_pcm_pkg::COEFS_PER_WORD + c] =
          word_q[w][c*fir_pcm_pkg::COEF_W +: fir_pcm_pkg::COEF_W];
      end
    end
  end

endmodule

// ===== hw/rtl/fir_pcm_tapline.sv =====
// Input register and sample history: forms the tap vector for each request.
// Depends on fir_pcm_pkg.
module fir_pcm_tapline #(
  parameter int unsigned TAPS = 16
) (
  input  logic                                                      clk_i,
  input  logic                                                      rst_ni,
  input  logic                                                      valid_i,
  output logic                                                      ready_o,
  input  logic [fir_pcm_pkg::SAMPLE_W-1:0]                          sample_i,
  output logic                                                      valid_o,
  input  logic                                                      ready_i,
  output logic [fir_pcm_pkg::NUM_COEFS-1:0][fir_pcm_pkg::SAMPLE_W-1:0] taps_o
);

  localparam int unsigned HIST_DEPTH = TAPS - 1;

  logic [fir_pcm_pkg::SAMPLE_W-1:0]                           hist_q [HIST_DEPTH];
  logic [fir_pcm_pkg::NUM_COEFS-1:0][fir_pcm_pkg::SAMPLE_W-1:0] taps_d, taps_q;
  logic valid_q;
  logic accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign taps_d[0] = sample_i;
  for (genvar j = 1; j < fir_pcm_pkg::NUM_COEFS; j++) begin : g_tap
    if (j < TAPS) begin : g_hist
      assign taps_d[j] = hist_q[j-1];
    end else begin : g_none
      assign taps_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (accept) begin
        hist_q[0] <= sample_i;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      taps_q <= taps_d;
    end
  end

  assign valid_o = valid_q;
  assign taps_o  = taps_q;

endmodule

// ===== hw/rtl/fir_pcm_mac.sv =====
// Tap multipliers (one per coefficient) and registered partial sums of four.
// Depends on fir_pcm_pkg.
module fir_pcm_mac (
  input  logic                                                        clk_i,
  input  logic                                                        rst_ni,
  input  fir_pcm_pkg::cfg_t                                           cfg_i,
  input  logic                                                        valid_i,
  output logic                                                        ready_o,
  input  logic [fir_pcm_pkg::NUM_COEFS-1:0][fir_pcm_pkg::SAMPLE_W-1:0] taps_i,
  output logic                                                        valid_o,
  input  logic                                                        ready_i,
  output logic signed [fir_pcm_pkg::PSUM_W-1:0]                       psum_o [fir_pcm_pkg::NUM_GRP]
);

  logic signed [fir_pcm_pkg::PROD_W-1:0] prod_d [fir_pcm_pkg::NUM_COEFS];
  logic signed [fir_pcm_pkg::PROD_W-1:0] prod_q [fir_pcm_pkg::NUM_COEFS];
  logic signed [fir_pcm_pkg::PSUM_W-1:0] psum_d [fir_pcm_pkg::NUM_GRP];
  logic signed [fir_pcm_pkg::PSUM_W-1:0] psum_q [fir_pcm_pkg::NUM_GRP];
  logic prod_vld_q, psum_vld_q;
  logic prod_rdy, psum_rdy;

  assign psum_rdy = !psum_vld_q || ready_i;
  assign prod_rdy = !prod_vld_q || psum_rdy;
  assign ready_o  = prod_rdy;

  // taps at or beyond the tap count contribute nothing
  always_comb begin
    for (int j = 0; j < fir_pcm_pkg::NUM_COEFS; j++) begin
      if (cfg_i.tap_count > fir_pcm_pkg::TAP_CNT_W'(j)) begin
        prod_d[j] = $signed(taps_i[j]) * $signed(cfg_i.coef[j]);
      end else begin
        prod_d[j] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < fir_pcm_pkg::NUM_GRP; g++) begin
      psum_d[g] = '0;
      for (int k = 0; k < fir_pcm_pkg::GRP; k++) begin
        psum_d[g] = psum_d[g] + fir_pcm_pkg::PSUM_W'(prod_q[g*fir_pcm_pkg::GRP + k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      psum_vld_q <= 1'b0;
    end else begin
      if (prod_rdy) begin
        prod_vld_q <= valid_i;
      end
      if (psum_rdy) begin
        psum_vld_q <= prod_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && prod_rdy) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q && psum_rdy) begin
      psum_q <= psum_d;
    end
  end

  assign valid_o = psum_vld_q;
  assign psum_o  = psum_q;

endmodule

// ===== hw/rtl/fir_pcm_out.sv =====
// Final sum, round half up, arithmetic shift, saturation and result register.
// Depends on fir_pcm_pkg.
module fir_pcm_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [fir_pcm_pkg::PSUM_W-1:0] psum_i [fir_pcm_pkg::NUM_GRP],
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [fir_pcm_pkg::SAMPLE_W-1:0]      sample_o,
  output logic                                  clipped_o
);

  localparam int unsigned ACC_W = fir_pcm_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] RND =
    ACC_W'(1) << (fir_pcm_pkg::COEF_FRAC_BITS - 1);

  logic signed [ACC_W-1:0] acc, shifted;
  logic [ACC_W-fir_pcm_pkg::SAMPLE_W:0] upper;
  logic ovf;
  logic [fir_pcm_pkg::SAMPLE_W-1:0] sample_d, sample_q;
  logic clipped_q, valid_q;

  always_comb begin
    acc = RND;
    for (int g = 0; g < fir_pcm_pkg::NUM_GRP; g++) begin
      acc = acc + ACC_W'(psum_i[g]);
    end
    shifted = acc >>> fir_pcm_pkg::COEF_FRAC_BITS;
    upper   = shifted[ACC_W-1:fir_pcm_pkg::SAMPLE_W-1];
    ovf     = !((&upper) || !(|upper));
    if (ovf) begin
      sample_d = shifted[ACC_W-1] ? {1'b1, {(fir_pcm_pkg::SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(fir_pcm_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      sample_d = shifted[fir_pcm_pkg::SAMPLE_W-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sample_q  <= sample_d;
      clipped_q <= ovf;
    end
  end

  assign valid_o   = valid_q;
  assign sample_o  = sample_q;
  assign clipped_o = clipped_q;

endmodule

// ===== hw/rtl/fir_filter_pcm16_top.sv =====
// Top level of the streaming PCM16 FIR filter.
// Depends on fir_pcm_pkg, fir_pcm_regs, fir_pcm_tapline, fir_pcm_mac, fir_pcm_out.
//
// Usage:
//   s_axis carries one signed 16-bit sample per request; m_axis returns one
//   filtered sample per input, with tuser set when saturation changed it.
//   Coefficients (signed Q2.14, four per 64-bit word, tap 0 lowest) and the
//   tap count are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
//   Each request passes through the input register, product register,
//   partial-sum register and result register. Throughput: one sample per
//   cycle while m_axis_tready stays high.
//   Every stage has its own valid and a ready chain, so bubbles close up and
//   input keeps flowing while a result waits, until all four stages are full;
//   then s_axis_tready drops until m_axis_tready returns.
//   Reset clears the sample history (earlier samples count as zero), sets the
//   tap count to 1 and coefficient 0 to unity, all others to zero.
module fir_filter_pcm16_top #(
  parameter int unsigned TAPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [15:0]                           s_axis_tdata,   // [15:0] sample_in
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [15:0]                           m_axis_tdata,   // [15:0] sample_out
  output logic                                  m_axis_tuser,   // [0] clipped
  input  logic                                  cfg_we_i,
  input  logic [fir_pcm_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fir_pcm_pkg::WORD_W-1:0]        cfg_data_i
);

  fir_pcm_pkg::cfg_t cfg;
  logic tap_vld, tap_rdy, sum_vld, sum_rdy;
  logic [fir_pcm_pkg::NUM_COEFS-1:0][fir_pcm_pkg::SAMPLE_W-1:0] taps;
  logic signed [fir_pcm_pkg::PSUM_W-1:0] psum [fir_pcm_pkg::NUM_GRP];

  fir_pcm_regs u_regs (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o      (cfg)
  );

  fir_pcm_tapline #(
    .TAPS (TAPS)
  ) u_tapline (
    .clk_i,
    .rst_ni,
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .sample_i (s_axis_tdata),
    .valid_o  (tap_vld),
    .ready_i  (tap_rdy),
    .taps_o   (taps)
  );

  fir_pcm_mac u_mac (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg),
    .valid_i (tap_vld),
    .ready_o (tap_rdy),
    .taps_i  (taps),
    .valid_o (sum_vld),
    .ready_i (sum_rdy),
    .psum_o  (psum)
  );

  fir_pcm_out u_out (
    .clk_i,
    .rst_ni,
    .valid_i   (sum_vld),
    .ready_o   (sum_rdy),
    .psum_i    (psum),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .sample_o  (m_axis_tdata),
    .clipped_o (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/fir_pcm_checker.sv =====
// Port-level checks for the PCM16 FIR filter, bound to the top level.
// Depends on fir_filter_pcm16_top port names.
module fir_pcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // clipped results sit on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 16'h7fff) || (m_axis_tdata == 16'h8000))
    else $error("clip flag without saturated value");

  // a free-running sink never back-pressures the input
  a_ready_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with sink ready");

  // result arrives through all pipeline registers while the sink stays ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind fir_filter_pcm16_top fir_pcm_checker u_chk (.*);
